// ----- sv/lc2k_pkg.sv -----
// Shared types and constants for the LC-2K instruction executor.
// Depends on nothing; lc2k_regfile and the top level import it.
package lc2k_pkg;

    // Architectural sizes.
    localparam int WORD_W   = 32;
    localparam int RIDX_W   = 3;
    localparam int NUM_REGS = 8;
    localparam int PC_W     = 16;

    // Instruction field positions.
    localparam int OPC_MSB = 24;
    localparam int OPC_LSB = 22;
    localparam int RS_MSB  = 21;
    localparam int RS_LSB  = 19;
    localparam int RT_MSB  = 18;
    localparam int RT_LSB  = 16;
    localparam int OFF_MSB = 15;
    localparam int RD_MSB  = 2;

    // Instruction opcodes.
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NAND = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } t_opcode;

    // Input item kinds.
    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_STEP = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_LOAD,
        S_HOLD
    } t_state;

    // Input transaction payload.
    typedef struct packed {
        logic                     op;
        logic [15:0]              load_address;
        logic signed [WORD_W-1:0] load_data;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic [PC_W-1:0]          program_counter;
        logic                     halted;
        logic [2:0]               executed_opcode;
        logic                     reg_written;
        logic [RIDX_W-1:0]        reg_index;
        logic signed [WORD_W-1:0] reg_value;
        logic                     mem_written;
        logic [15:0]              mem_address;
        logic signed [WORD_W-1:0] mem_value;
    } t_out_item;

    // Register file control from the sequencer.
    typedef struct packed {
        logic              rd_en;
        logic [RIDX_W-1:0] rs;
        logic [RIDX_W-1:0] rt;
        logic              wr_en;
        logic [RIDX_W-1:0] wr_idx;
        logic [WORD_W-1:0] wr_data;
    } t_rf_ctl;

endpackage

// ----- sv/lc2k_ram.sv -----
// Generic synchronous RAM: one write port and one registered read port.
// Depends on nothing.
module lc2k_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and read port; read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lc2k_regfile.sv -----
// Eight-entry register file: two RAM copies give two read ports.
// Depends on lc2k_pkg and lc2k_ram.
module lc2k_regfile
    import lc2k_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rf_ctl           i_ctl,
    output logic [WORD_W-1:0] o_rs_val,
    output logic [WORD_W-1:0] o_rt_val
);

    logic [NUM_REGS-1:0] r_valid;
    logic                r_rs_ok;
    logic                r_rt_ok;
    logic [WORD_W-1:0]   rs_raw;
    logic [WORD_W-1:0]   rt_raw;

    // Both copies see every write so that they stay identical.
    lc2k_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_copy_rs (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_ctl.wr_idx),
        .i_wdata (i_ctl.wr_data),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rs),
        .o_rdata (rs_raw)
    );

    lc2k_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_copy_rt (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_ctl.wr_idx),
        .i_wdata (i_ctl.wr_data),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rt),
        .o_rdata (rt_raw)
    );

    // Valid bits stand in for the zero reset of the register contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rs_ok <= 1'b0;
            r_rt_ok <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_idx] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rs_ok <= r_valid[i_ctl.rs];
                r_rt_ok <= r_valid[i_ctl.rt];
            end
        end
    end

    // A register never written since reset reads as zero.
    assign o_rs_val = r_rs_ok ? rs_raw : '0;
    assign o_rt_val = r_rt_ok ? rt_raw : '0;

endmodule

// ----- sv/lc2k_instruction_executor.sv -----
// Top level of the LC-2K instruction executor: sequencer, datapath, output register.
// Depends on lc2k_pkg, lc2k_ram (main memory) and lc2k_regfile.
//
//  Channel  | Signals                               | Direction | Payload
//  ---------+---------------------------------------+-----------+-----------
//  in       | i_in_valid, o_in_ready, i_in_data     | to core   | t_in_item
//  out      | o_out_valid, i_out_ready, o_out_data  | from core | t_out_item
//
// A load item, and a step after halt, finish in the idle state. A step goes
// through instruction fetch, register read and execute; lw adds a load state,
// as its data read shares the main memory port with the fetch.
// Reset clears pc, the halt flag and the register valid bits at once; main
// memory is not cleared. A finished result goes to the output register; while
// that register is occupied and not taken, the result waits in a holding
// register and no new transaction is accepted.
// MEM_DEPTH must be a power of two (not enforced); addresses and pc wrap by masking.
module lc2k_instruction_executor
    import lc2k_pkg::*;
#(
    parameter int MEM_DEPTH = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MEM_DEPTH);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_pc, n_pc;
    logic              r_halt, n_halt;
    logic [WORD_W-1:0] r_ir, n_ir;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    t_out_item         r_res, n_res;

    logic              in_acc;
    logic              slot_free;
    logic              done;
    t_out_item         res;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    t_rf_ctl           rf_ctl;
    logic [WORD_W-1:0] rs_val;
    logic [WORD_W-1:0] rt_val;

    t_opcode           opc;
    logic [RIDX_W-1:0] ir_rs;
    logic [RIDX_W-1:0] ir_rt;
    logic [RIDX_W-1:0] ir_rd;
    logic [AW-1:0]     pc_inc;
    logic [AW-1:0]     data_addr;

    // Main memory holds program and data words.
    lc2k_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_main_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lc2k_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rf_ctl),
        .o_rs_val (rs_val),
        .o_rt_val (rt_val)
    );

    // Handshakes.
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Decode of the latched instruction.
    assign opc   = t_opcode'(r_ir[OPC_MSB:OPC_LSB]);
    assign ir_rs = r_ir[RS_MSB:RS_LSB];
    assign ir_rt = r_ir[RT_MSB:RT_LSB];
    assign ir_rd = r_ir[RD_MSB:0];

    // The sign-extended offset wraps to the same low address bits.
    assign pc_inc    = r_pc + AW'(1);
    assign data_addr = rs_val[AW-1:0] + r_ir[AW-1:0];

    // Sequencer and execute datapath.
    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_halt    = r_halt;
        n_ir      = r_ir;
        n_res     = r_res;
        done      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_pc;
        rf_ctl    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.op == ITEM_LOAD) begin
                        mem_we    = 1'b1;
                        mem_waddr = i_in_data.load_address[AW-1:0];
                        mem_wdata = i_in_data.load_data;
                        done      = 1'b1;
                    end else if (r_halt) begin
                        done = 1'b1;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_ir         = mem_rdata;
                rf_ctl.rd_en = 1'b1;
                rf_ctl.rs    = mem_rdata[RS_MSB:RS_LSB];
                rf_ctl.rt    = mem_rdata[RT_MSB:RT_LSB];
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                n_pc = pc_inc;
                case (opc)
                    OP_ADD: begin
                        rf_ctl.wr_en   = 1'b1;
                        rf_ctl.wr_idx  = ir_rd;
                        rf_ctl.wr_data = rs_val + rt_val;
                        done           = 1'b1;
                    end
                    OP_NAND: begin
                        rf_ctl.wr_en   = 1'b1;
                        rf_ctl.wr_idx  = ir_rd;
                        rf_ctl.wr_data = ~(rs_val & rt_val);
                        done           = 1'b1;
                    end
                    OP_LW: begin
                        // The pc commits with the register write, in S_LOAD.
                        n_pc      = r_pc;
                        mem_re    = 1'b1;
                        mem_raddr = data_addr;
                        n_state   = S_LOAD;
                    end
                    OP_SW: begin
                        mem_we    = 1'b1;
                        mem_waddr = data_addr;
                        mem_wdata = rt_val;
                        done      = 1'b1;
                    end
                    OP_BEQ: begin
                        if (rs_val == rt_val) begin
                            n_pc = pc_inc + r_ir[AW-1:0];
                        end
                        done = 1'b1;
                    end
                    OP_JALR: begin
                        rf_ctl.wr_en   = 1'b1;
                        rf_ctl.wr_idx  = ir_rt;
                        rf_ctl.wr_data = WORD_W'(pc_inc);
                        // With rs equal to rt the jump sees the new link value.
                        n_pc = (ir_rs == ir_rt) ? pc_inc : rs_val[AW-1:0];
                        done = 1'b1;
                    end
                    OP_HALT: begin
                        n_halt = 1'b1;
                        done   = 1'b1;
                    end
                    OP_NOOP: begin
                        done = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            S_LOAD: begin
                rf_ctl.wr_en   = 1'b1;
                rf_ctl.wr_idx  = ir_rt;
                rf_ctl.wr_data = mem_rdata;
                n_pc           = pc_inc;
                done           = 1'b1;
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Result of the transaction that finishes in this cycle.
        res                 = '0;
        res.program_counter = PC_W'(n_pc);
        res.halted          = n_halt;
        if (r_state != S_IDLE) begin
            res.executed_opcode = opc;
        end
        res.reg_written = rf_ctl.wr_en;
        res.reg_index   = rf_ctl.wr_idx;
        res.reg_value   = rf_ctl.wr_data;
        if (r_state == S_EXEC && opc == OP_SW) begin
            res.mem_written = 1'b1;
            res.mem_address = 16'(mem_waddr);
            res.mem_value   = mem_wdata;
        end

        // A finished result goes to the output or waits in the holding register.
        if (done) begin
            if (slot_free) begin
                n_state = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_HOLD;
            end
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (done && slot_free) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (r_state == S_HOLD && slot_free) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ir  <= n_ir;
        r_res <= n_res;
        r_out <= n_out;
    end

    // The halt flag is sticky.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared after it was set");

    // Once halted, the pc no longer moves.
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_pc))
        else $error("pc changed while halted");

    // A held result means the output register is occupied.
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("result held while output register is empty");

    // A step accepted before halt starts with an instruction fetch.
    a_step_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == ITEM_STEP && !r_halt) |=> (r_state == S_FETCH))
        else $error("step transaction did not start a fetch");

endmodule
